// File: sv/cfbn_pkg.sv
// Package for the confidence filter and box suppression core.
// Holds field widths, defaults, register codes, controller states and the
// command and status words that pass between controller and datapath.
package cfbn_pkg;

    // Default store capacity in boxes.
    localparam int MAX_BOXES_DEF = 64;

    // Field widths.
    localparam int NORM_W  = 16;
    localparam int PX_W    = 13;
    localparam int EXT_W   = 14;
    localparam int SCORE_W = 16;
    localparam int CLASS_W = 8;
    localparam int PCT_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // One stored box: {class, score, bottom, right, top, left}.
    localparam int BOX_W = CLASS_W + SCORE_W + 4 * PX_W;

    // Register reset values.
    localparam logic [SCORE_W-1:0] THR_RST = 16'd32768;
    localparam logic [PCT_W-1:0]   PCT_RST = 7'd50;
    localparam logic [PX_W-1:0]    DIM_RST = 13'd640;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCORE_THR = 2'd0,
        CFG_OVERLAP   = 2'd1,
        CFG_IMG_W     = 2'd2,
        CFG_IMG_H     = 2'd3
    } cfg_reg_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_STORE,
        ST_ROW_START,
        ST_ROW_RD,
        ST_ROW_LOAD,
        ST_ROW_AREA,
        ST_PAIR,
        ST_DRAIN,
        ST_ROW_END,
        ST_EMIT_START,
        ST_EMIT_RD,
        ST_EMIT_CHK,
        ST_EMPTY,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // latch the input word
        logic scale;       // convert corners to pixels
        logic box_we;      // write the box store at the write address
        logic keep_set;    // set the keep mark at the write address
        logic row_load;    // load box i from the read data
        logic row_area;    // work out the area of box i
        logic pair_issue;  // a pair read is in flight this cycle
        logic keep_row;    // write back the keep mark of box i
        logic out_load;    // load a kept box into the output register
        logic out_empty;   // load the empty frame result
        logic out_last;    // result is the last of the frame
        logic out_ovf;     // overflow flag of the frame
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pass;        // latched score reaches the threshold
        logic item_last;   // latched word closes the frame
        logic pipe_busy;   // pair tests still in flight
        logic keep_i;      // keep mark of box i
        logic rd_keep;     // keep mark at the read address
        logic out_free;    // output register can take a word
    } sts_t;

endpackage

// File: sv/cfbn_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module cfbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/cfbn_dp.sv
// Datapath: configuration registers, pixel scaling, box and keep stores,
// the overlap test pipeline and the output register.
// Depends on cfbn_pkg and cfbn_ram.
module cfbn_dp
    import cfbn_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic [NORM_W-1:0]            corner_left,
    input  logic [NORM_W-1:0]            corner_top,
    input  logic [NORM_W-1:0]            corner_right,
    input  logic [NORM_W-1:0]            corner_bottom,
    input  logic [SCORE_W-1:0]           box_score,
    input  logic [CLASS_W-1:0]           class_label,
    input  logic                         frame_last,
    input  cmd_t                         cmd,
    input  logic [$clog2(MAX_BOXES)-1:0] rd_addr,
    input  logic [$clog2(MAX_BOXES)-1:0] wr_addr,
    output sts_t                         sts,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [PX_W-1:0]              left_px,
    output logic [PX_W-1:0]              top_px,
    output logic signed [EXT_W-1:0]      width_px,
    output logic signed [EXT_W-1:0]      height_px,
    output logic [SCORE_W-1:0]           kept_score,
    output logic [CLASS_W-1:0]           kept_class,
    output logic                         last_of_frame,
    output logic                         frame_empty,
    output logic                         overflowed
);

    localparam int IDX_W = $clog2(MAX_BOXES);

    // Coordinates above 1.0 and sizes above 4096 saturate before scaling.
    function automatic logic [PX_W-1:0] to_px(input logic [NORM_W-1:0] c,
                                              input logic [PX_W-1:0] d);
        logic [NORM_W-1:0] cs;
        logic [PX_W-1:0]   ds;
        logic [28:0]       prod;
        cs   = (c > 16'd32768) ? 16'd32768 : c;
        ds   = (d > 13'd4096) ? 13'd4096 : d;
        prod = 29'(cs) * 29'(ds);
        return prod[27:15];
    endfunction

    function automatic logic signed [EXT_W-1:0] span(input logic [PX_W-1:0] lo,
                                                     input logic [PX_W-1:0] hi);
        return $signed({1'b0, hi}) - $signed({1'b0, lo});
    endfunction

    // Configuration registers.
    logic [SCORE_W-1:0] thr_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [PX_W-1:0]    img_w_reg;
    logic [PX_W-1:0]    img_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RST;
            pct_reg   <= PCT_RST;
            img_w_reg <= DIM_RST;
            img_h_reg <= DIM_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SCORE_THR: thr_reg   <= cfg_data;
                CFG_OVERLAP:   pct_reg   <= cfg_data[PCT_W-1:0];
                CFG_IMG_W:     img_w_reg <= cfg_data[PX_W-1:0];
                CFG_IMG_H:     img_h_reg <= cfg_data[PX_W-1:0];
                default:       ;
            endcase
        end
    end

    // Input word and its pixel corners.
    logic [NORM_W-1:0]  in_l_reg, in_t_reg, in_r_reg, in_b_reg;
    logic [SCORE_W-1:0] in_score_reg;
    logic [CLASS_W-1:0] in_class_reg;
    logic               in_last_reg;
    logic [PX_W-1:0]    px_l_reg, px_t_reg, px_r_reg, px_b_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            in_l_reg     <= corner_left;
            in_t_reg     <= corner_top;
            in_r_reg     <= corner_right;
            in_b_reg     <= corner_bottom;
            in_score_reg <= box_score;
            in_class_reg <= class_label;
            in_last_reg  <= frame_last;
        end
        if (cmd.scale)
        begin
            px_l_reg <= to_px(in_l_reg, img_w_reg);
            px_t_reg <= to_px(in_t_reg, img_h_reg);
            px_r_reg <= to_px(in_r_reg, img_w_reg);
            px_b_reg <= to_px(in_b_reg, img_h_reg);
        end
    end

    // Box store and keep marks.
    logic [BOX_W-1:0] box_rdata;
    logic [0:0]       keep_rdata;
    logic             keep_we;
    logic [IDX_W-1:0] keep_waddr;
    logic [0:0]       keep_wdata;
    logic             dec_clr_i;
    logic             dec_clr_j;
    logic [IDX_W-1:0] s4_j_reg;

    cfbn_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
        .clk   (clk),
        .we    (cmd.box_we),
        .waddr (wr_addr),
        .wdata ({in_class_reg, in_score_reg, px_b_reg, px_r_reg, px_t_reg, px_l_reg}),
        .raddr (rd_addr),
        .rdata (box_rdata)
    );

    cfbn_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_keep_ram (
        .clk   (clk),
        .we    (keep_we),
        .waddr (keep_waddr),
        .wdata (keep_wdata),
        .raddr (rd_addr),
        .rdata (keep_rdata)
    );

    // Fields of the read word.
    logic [PX_W-1:0]    rd_l, rd_t, rd_r, rd_b;
    logic [SCORE_W-1:0] rd_score;
    logic [CLASS_W-1:0] rd_class;

    assign rd_l     = box_rdata[PX_W-1:0];
    assign rd_t     = box_rdata[2*PX_W-1:PX_W];
    assign rd_r     = box_rdata[3*PX_W-1:2*PX_W];
    assign rd_b     = box_rdata[4*PX_W-1:3*PX_W];
    assign rd_score = box_rdata[4*PX_W+SCORE_W-1:4*PX_W];
    assign rd_class = box_rdata[BOX_W-1:4*PX_W+SCORE_W];

    // Box i held for the duration of its row.
    logic [PX_W-1:0]    bi_l_reg, bi_t_reg, bi_r_reg, bi_b_reg;
    logic [SCORE_W-1:0] bi_score_reg;
    logic               keep_i_reg;
    logic signed [27:0] area_i_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.row_load)
        begin
            bi_l_reg     <= rd_l;
            bi_t_reg     <= rd_t;
            bi_r_reg     <= rd_r;
            bi_b_reg     <= rd_b;
            bi_score_reg <= rd_score;
            keep_i_reg   <= keep_rdata[0];
        end
        else if (dec_clr_i)
        begin
            keep_i_reg <= 1'b0;
        end
        if (cmd.row_area)
        begin
            area_i_reg <= 28'(span(bi_l_reg, bi_r_reg)) * 28'(span(bi_t_reg, bi_b_reg));
        end
    end

    // Overlap test pipeline: read, overlap spans, products, union, scaled
    // products, then the decision.
    logic               p0_v_reg, s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic [IDX_W-1:0]   p0_j_reg, s1_j_reg, s2_j_reg, s3_j_reg;
    logic [SCORE_W-1:0] s1_sc_reg, s2_sc_reg, s3_sc_reg, s4_sc_reg;
    logic [PX_W-1:0]    s1_iw_reg, s1_ih_reg;
    logic signed [EXT_W-1:0] s1_wj_reg, s1_hj_reg;
    logic [25:0]        s2_inter_reg, s3_inter_reg;
    logic signed [27:0] s2_aj_reg;
    logic signed [29:0] s3_uni_reg;
    logic [35:0]        s4_pa_reg, s4_pb_reg;
    logic               s4_pos_reg;

    logic signed [EXT_W-1:0] ov_w, ov_h;
    logic [PX_W-1:0]         min_r, max_l, min_b, max_t;

    always_comb
    begin
        min_r = (bi_r_reg < rd_r) ? bi_r_reg : rd_r;
        max_l = (bi_l_reg > rd_l) ? bi_l_reg : rd_l;
        min_b = (bi_b_reg < rd_b) ? bi_b_reg : rd_b;
        max_t = (bi_t_reg > rd_t) ? bi_t_reg : rd_t;
        ov_w  = span(max_l, min_r);
        ov_h  = span(max_t, min_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            p0_v_reg <= cmd.pair_issue;
            s1_v_reg <= p0_v_reg;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_j_reg     <= rd_addr;
        s1_j_reg     <= p0_j_reg;
        s1_sc_reg    <= rd_score;
        s1_iw_reg    <= ov_w[EXT_W-1] ? '0 : ov_w[PX_W-1:0];
        s1_ih_reg    <= ov_h[EXT_W-1] ? '0 : ov_h[PX_W-1:0];
        s1_wj_reg    <= span(rd_l, rd_r);
        s1_hj_reg    <= span(rd_t, rd_b);
        s2_j_reg     <= s1_j_reg;
        s2_sc_reg    <= s1_sc_reg;
        s2_inter_reg <= 26'(s1_iw_reg) * 26'(s1_ih_reg);
        s2_aj_reg    <= 28'(s1_wj_reg) * 28'(s1_hj_reg);
        s3_j_reg     <= s2_j_reg;
        s3_sc_reg    <= s2_sc_reg;
        s3_inter_reg <= s2_inter_reg;
        s3_uni_reg   <= 30'(area_i_reg) + 30'(s2_aj_reg) - $signed({4'b0, s2_inter_reg});
        s4_j_reg     <= s3_j_reg;
        s4_sc_reg    <= s3_sc_reg;
        s4_pos_reg   <= (s3_uni_reg > 30'sd0);
        s4_pa_reg    <= 36'(s3_inter_reg) * 36'd100;
        s4_pb_reg    <= 36'(pct_reg) * 36'(s3_uni_reg[28:0]);
    end

    // The lower score loses; box i loses only to a strictly higher score.
    logic dec_hit;

    always_comb
    begin
        dec_hit   = s4_v_reg && s4_pos_reg && (s4_pa_reg >= s4_pb_reg);
        dec_clr_i = dec_hit && (s4_sc_reg > bi_score_reg);
        dec_clr_j = dec_hit && !(s4_sc_reg > bi_score_reg);
    end

    // Keep mark write port.
    always_comb
    begin
        keep_we    = 1'b0;
        keep_waddr = wr_addr;
        keep_wdata = 1'b0;
        if (dec_clr_j)
        begin
            keep_we    = 1'b1;
            keep_waddr = s4_j_reg;
        end
        else if (cmd.keep_set)
        begin
            keep_we    = 1'b1;
            keep_wdata = 1'b1;
        end
        else if (cmd.keep_row)
        begin
            keep_we    = 1'b1;
            keep_wdata = keep_i_reg;
        end
    end

    // Output register.
    logic out_valid_reg;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load || cmd.out_empty)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            left_px       <= rd_l;
            top_px        <= rd_t;
            width_px      <= span(rd_l, rd_r);
            height_px     <= span(rd_t, rd_b);
            kept_score    <= rd_score;
            kept_class    <= rd_class;
            last_of_frame <= cmd.out_last;
            frame_empty   <= 1'b0;
            overflowed    <= cmd.out_ovf;
        end
        else if (cmd.out_empty)
        begin
            left_px       <= '0;
            top_px        <= '0;
            width_px      <= '0;
            height_px     <= '0;
            kept_score    <= '0;
            kept_class    <= '0;
            last_of_frame <= 1'b1;
            frame_empty   <= 1'b1;
            overflowed    <= cmd.out_ovf;
        end
    end

    assign out_valid = out_valid_reg;

    // Status back to the controller.
    always_comb
    begin
        sts.pass      = (in_score_reg >= thr_reg);
        sts.item_last = in_last_reg;
        sts.pipe_busy = p0_v_reg || s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg;
        sts.keep_i    = keep_i_reg;
        sts.rd_keep   = keep_rdata[0];
        sts.out_free  = out_free;
    end

    // A stalled output word is never overwritten.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !((cmd.out_load || cmd.out_empty) && out_valid_reg && out_stall))
        else $error("output word overwritten while stalled");

    // A stalled output word stays valid and unchanged.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg &&
        $stable({left_px, top_px, width_px, height_px, kept_score, kept_class,
                 last_of_frame, frame_empty, overflowed})))
        else $error("stalled output word changed");

    // Suppression decisions never collide with controller keep writes.
    a_keep_port: assert property (@(posedge clk) disable iff (!rst_n)
        dec_hit |-> !(cmd.keep_set || cmd.keep_row || cmd.row_load))
        else $error("keep mark write collision");

endmodule

// File: sv/cfbn_ctrl.sv
// Controller: sequences storing, the pairwise suppression rows and the
// emission of kept boxes. Depends on cfbn_pkg.
module cfbn_ctrl
    import cfbn_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  sts_t                         sts,
    output cmd_t                         cmd,
    output logic [$clog2(MAX_BOXES)-1:0] rd_addr,
    output logic [$clog2(MAX_BOXES)-1:0] wr_addr
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_BOXES);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic             any_reg, any_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] i_inc, j_inc;

    assign i_inc = i_reg + 1'b1;
    assign j_inc = j_reg + 1'b1;

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            last_reg  <= '0;
            any_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            last_reg  <= last_next;
            any_reg   <= any_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        last_next  = last_reg;
        any_next   = any_reg;
        ovf_next   = ovf_reg;
        cmd        = '0;
        cmd.out_ovf = ovf_reg;
        cmd.out_last = (i_reg[IDX_W-1:0] == last_reg);
        rd_addr    = i_reg[IDX_W-1:0];
        wr_addr    = i_reg[IDX_W-1:0];
        in_stall   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                wr_addr = count_reg[IDX_W-1:0];
                if (sts.pass)
                begin
                    if (count_reg < CAP)
                    begin
                        cmd.box_we   = 1'b1;
                        cmd.keep_set = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                state_next = sts.item_last ? ST_ROW_START : ST_IDLE;
            end
            ST_ROW_START:
            begin
                i_next     = '0;
                any_next   = 1'b0;
                state_next = (count_reg == '0) ? ST_EMPTY : ST_ROW_RD;
            end
            ST_ROW_RD:
            begin
                state_next = ST_ROW_LOAD;
            end
            ST_ROW_LOAD:
            begin
                cmd.row_load = 1'b1;
                j_next       = i_inc;
                state_next   = (i_inc >= count_reg) ? ST_ROW_END : ST_ROW_AREA;
            end
            ST_ROW_AREA:
            begin
                cmd.row_area = 1'b1;
                state_next   = ST_PAIR;
            end
            ST_PAIR:
            begin
                rd_addr        = j_reg[IDX_W-1:0];
                cmd.pair_issue = 1'b1;
                j_next         = j_inc;
                if (j_inc >= count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_ROW_END;
                end
            end
            ST_ROW_END:
            begin
                cmd.keep_row = 1'b1;
                if (sts.keep_i)
                begin
                    last_next = i_reg[IDX_W-1:0];
                    any_next  = 1'b1;
                end
                if (i_inc >= count_reg)
                begin
                    state_next = ST_EMIT_START;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_ROW_RD;
                end
            end
            ST_EMIT_START:
            begin
                i_next     = '0;
                state_next = any_reg ? ST_EMIT_RD : ST_EMPTY;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_CHK;
            end
            ST_EMIT_CHK:
            begin
                if (!sts.rd_keep)
                begin
                    i_next     = i_inc;
                    state_next = ST_EMIT_RD;
                end
                else if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (i_reg[IDX_W-1:0] == last_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.out_empty = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The store never holds more boxes than it has slots.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("stored box count exceeds capacity");

    // A row only closes once every pair test of it has been decided.
    a_row_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROW_END) |-> !sts.pipe_busy)
        else $error("row closed with pair tests in flight");

    // Pair reads stay inside the filled part of the store.
    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAIR) |-> (j_reg < count_reg && j_reg > i_reg))
        else $error("pair read outside the stored boxes");

endmodule

// File: sv/confidence_filter_box_nms_core.sv
// Top level of the confidence filter and box suppression core.
// Depends on cfbn_pkg, cfbn_ctrl, cfbn_dp and cfbn_ram.
//
//  channel | handshake               | word
//  --------+-------------------------+--------------------------------------
//  in      | in_valid / in_stall     | corners, score, class, frame_last
//  out     | out_valid / out_stall   | pixel box, score, class, frame flags
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Each input word is accepted, scaled and stored in turn; the next is taken
// once the one before is stored. The word that closes a frame of n stored
// boxes then runs one row per box (read, load, area, one pair test per cycle
// for each later box, pipeline drain, write-back; the last row has only read,
// load and write-back), then reads and checks each stored box up to the last
// kept one to emit kept boxes, plus output stalls and states to start the
// rows, start emission and finish. Reset clears control state; the box stores
// need no clearing. A stalled output holds its word while input words keep
// being taken until the frame end needs the output register.
module confidence_filter_box_nms_core
    import cfbn_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [NORM_W-1:0]       corner_left,
    input  logic [NORM_W-1:0]       corner_top,
    input  logic [NORM_W-1:0]       corner_right,
    input  logic [NORM_W-1:0]       corner_bottom,
    input  logic [SCORE_W-1:0]      box_score,
    input  logic [CLASS_W-1:0]      class_label,
    input  logic                    frame_last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [PX_W-1:0]         left_px,
    output logic [PX_W-1:0]         top_px,
    output logic signed [EXT_W-1:0] width_px,
    output logic signed [EXT_W-1:0] height_px,
    output logic [SCORE_W-1:0]      kept_score,
    output logic [CLASS_W-1:0]      kept_class,
    output logic                    last_of_frame,
    output logic                    frame_empty,
    output logic                    overflowed
);

    localparam int IDX_W = $clog2(MAX_BOXES);

    cmd_t             cmd;
    sts_t             sts;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    // Register writes are taken at any time.
    assign cfg_ready = 1'b1;

    cfbn_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    cfbn_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .corner_left   (corner_left),
        .corner_top    (corner_top),
        .corner_right  (corner_right),
        .corner_bottom (corner_bottom),
        .box_score     (box_score),
        .class_label   (class_label),
        .frame_last    (frame_last),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_px       (left_px),
        .top_px        (top_px),
        .width_px      (width_px),
        .height_px     (height_px),
        .kept_score    (kept_score),
        .kept_class    (kept_class),
        .last_of_frame (last_of_frame),
        .frame_empty   (frame_empty),
        .overflowed    (overflowed)
    );

endmodule
